/* hdl/lagged_multiplicative_rng_defines.svh */
// Assertion macros shared by the lagged multiplicative generator RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef LAGGED_MULTIPLICATIVE_RNG_DEFINES_SVH
`define LAGGED_MULTIPLICATIVE_RNG_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LMR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lmr_pkg.sv */
// Package for the lagged multiplicative generator: types, codes and constants.
// No dependencies; used by lmr_urem and lagged_multiplicative_rng.
`default_nettype none

package lmr_pkg;

  localparam int DEF_LONG_LAG  = 55;
  localparam int DEF_SHORT_LAG = 24;

  localparam int WORD_W  = 32;
  localparam int SEED_W  = 30;
  localparam int LIMIT_W = 31;
  localparam int DROP_BITS = 3;
  localparam int DRAW_W  = WORD_W - DROP_BITS;

  localparam logic [SEED_W-1:0] DEFAULT_SEED = SEED_W'(5297);

  // Discard count after seeding is DISC_BASE plus (u mod DISC_SPAN).
  localparam int DISC_W = 9;
  localparam logic [DISC_W-1:0] DISC_BASE = DISC_W'(400);
  localparam int DISC_SPAN = 100;

  // Remainder unit geometry.
  localparam int REM_DVD_W = WORD_W;
  localparam int REM_DSR_W = LIMIT_W;
  localparam int REM_CNT_W = $clog2(REM_DVD_W);

  typedef enum logic [1:0] {
    OP_RESEED  = 2'd0,
    OP_DRAW29  = 2'd1,
    OP_DRAW32  = 2'd2,
    OP_BOUNDED = 2'd3
  } lmr_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_DIV,
    ST_SEED_FILL,
    ST_DRAW_RD,
    ST_DRAW_MUL,
    ST_DRAW_WB,
    ST_MOD_WAIT,
    ST_FINISH
  } lmr_state_t;

  typedef struct packed {
    logic                 start;
    logic [REM_DVD_W-1:0] dividend;
    logic [REM_DSR_W-1:0] divisor;
  } lmr_rem_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [REM_DSR_W-1:0] remainder;
  } lmr_rem_rsp_t;

  // Seed word u = 2s + 1, the first ring entry of a fill.
  function automatic logic [WORD_W-1:0] seed_to_word(input logic [SEED_W-1:0] s);
    seed_to_word = {1'b0, s, 1'b1};
  endfunction

endpackage

`default_nettype wire

/* hdl/lmr_urem.sv */
// Iterative unsigned remainder unit, one restoring step per cycle.
// Depends on lmr_pkg for widths and the request/response structs.
`default_nettype none

module lmr_urem (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lmr_pkg::lmr_rem_req_t req,
  output lmr_pkg::lmr_rem_rsp_t     rsp
);
  import lmr_pkg::*;

  localparam logic [REM_CNT_W-1:0] LAST_STEP = REM_CNT_W'(REM_DVD_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [REM_DSR_W-1:0] dsr_r, dsr_nxt;
  logic [REM_DSR_W-1:0] rem_r, rem_nxt;
  logic [REM_DSR_W:0]   trial;
  logic [REM_DSR_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    // The partial remainder stays below the divisor, so its top bit is free.
    trial = {rem_r, dvd_r[REM_DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[REM_DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[REM_DSR_W-1:0];
      end else begin
        rem_nxt = trial[REM_DSR_W-1:0];
      end
      cnt_nxt = cnt_r + REM_CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

/* hdl/lagged_multiplicative_rng.sv */
// A seeded draw runs read, multiply and write-back steps per raw draw; a 32-bit draw takes two
// raw draws and a bounded draw adds the remainder unit. A reseed runs the remainder unit for
// u mod 100, fills the ring and runs 400 + u mod 100 discard draws, and the first draw after
// reset runs that seeding before its own draw. One transaction at a time.
// Reset (synchronous, rst_n low) clears cursor, seeded flag, sequencer and output valid;
// the seed register resets to 5297 and the ring stays undefined until the first seeding.
`default_nettype none
`include "lagged_multiplicative_rng_defines.svh"

module lagged_multiplicative_rng #(
  parameter int LONG_LAG  = lmr_pkg::DEF_LONG_LAG,
  parameter int SHORT_LAG = lmr_pkg::DEF_SHORT_LAG
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration: the seed register.
  input  wire logic                         cfg_we,
  input  wire logic [lmr_pkg::SEED_W-1:0]   cfg_wdata,
  // Request channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [lmr_pkg::LIMIT_W-1:0]  in_limit,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lmr_pkg::WORD_W-1:0]        out_random_value,
  output logic                              out_bad_limit
);
  import lmr_pkg::*;

  // Cursor arithmetic. The partner word sits PART_OFF places past the cursor,
  // which is always below twice the ring length, so one subtract wraps it.
  localparam int CUR_W = $clog2(LONG_LAG);
  localparam logic [CUR_W:0]   RING_LEN = (CUR_W + 1)'(LONG_LAG);
  localparam logic [CUR_W:0]   PART_OFF = (CUR_W + 1)'(LONG_LAG - (SHORT_LAG % LONG_LAG));
  localparam logic [CUR_W-1:0] LAST_IDX = CUR_W'(LONG_LAG - 1);

  // Sequencer and transaction context.
  lmr_state_t          state_r, state_nxt;
  lmr_op_t             op_r, op_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic                first_r, first_nxt;
  logic [DRAW_W-1:0]   x_r, x_nxt;
  logic                seeded_r, seeded_nxt;
  logic [CUR_W-1:0]    cur_r, cur_nxt;
  logic [CUR_W-1:0]    fill_idx_r, fill_idx_nxt;
  logic [WORD_W-1:0]   fill_val_r, fill_val_nxt;
  logic [DISC_W-1:0]   disc_cnt_r, disc_cnt_nxt;
  logic [WORD_W-1:0]   prod_r, prod_nxt;
  logic [WORD_W-1:0]   res_val_r, res_val_nxt;
  logic                res_bad_r, res_bad_nxt;
  logic [SEED_W-1:0]   seed_value_r;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_val_r, out_val_nxt;
  logic                out_bad_r, out_bad_nxt;

  // Lag ring memory with two registered read ports and one write port.
  logic [WORD_W-1:0] ring_mem [LONG_LAG];
  logic [WORD_W-1:0] rd_a_r, rd_b_r;
  logic              ring_we;
  logic [CUR_W-1:0]  ring_wa;
  logic [WORD_W-1:0] ring_wd;
  logic [CUR_W:0]    part_sum;
  logic [CUR_W:0]    part_wrap;
  logic [CUR_W-1:0]  part_idx;

  logic [DRAW_W-1:0] draw_val;
  logic              rem_start;
  lmr_rem_req_t      rem_req;
  lmr_rem_rsp_t      rem_rsp;

  always_comb begin
    part_sum  = {1'b0, cur_r} + PART_OFF;
    part_wrap = (part_sum >= RING_LEN) ? (part_sum - RING_LEN) : part_sum;
    part_idx  = part_wrap[CUR_W-1:0];
  end

  // The drawn value is the product with its low bits dropped.
  assign draw_val = prod_r[WORD_W-1:DROP_BITS];

  // The remainder unit serves two clients: u mod 100 while seeding, and the
  // bounded draw. Only the seeding start happens in ST_SEED_INIT.
  always_comb begin
    rem_req.start = rem_start;
    if (state_r == ST_SEED_INIT) begin
      rem_req.dividend = fill_val_r;
      rem_req.divisor  = REM_DSR_W'(DISC_SPAN);
    end else begin
      rem_req.dividend = {{DROP_BITS{1'b0}}, draw_val};
      rem_req.divisor  = limit_r;
    end
  end

  lmr_urem u_urem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    limit_nxt     = limit_r;
    first_nxt     = first_r;
    x_nxt         = x_r;
    seeded_nxt    = seeded_r;
    cur_nxt       = cur_r;
    fill_idx_nxt  = fill_idx_r;
    fill_val_nxt  = fill_val_r;
    disc_cnt_nxt  = disc_cnt_r;
    prod_nxt      = prod_r;
    res_val_nxt   = res_val_r;
    res_bad_nxt   = res_bad_r;
    ring_we       = 1'b0;
    ring_wa       = cur_r;
    ring_wd       = prod_r;
    rem_start     = 1'b0;
    // A waiting result leaves once the consumer takes it.
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_bad_nxt   = out_bad_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = lmr_op_t'(in_operation);
          limit_nxt   = in_limit;
          first_nxt   = 1'b0;
          res_val_nxt = '0;
          res_bad_nxt = 1'b0;
          priority if (lmr_op_t'(in_operation) == OP_RESEED) begin
            fill_val_nxt = seed_to_word(seed_value_r);
            state_nxt    = ST_SEED_INIT;
          end else if (lmr_op_t'(in_operation) == OP_BOUNDED && in_limit == '0) begin
            // A zero bound draws nothing and leaves the generator alone.
            res_bad_nxt = 1'b1;
            state_nxt   = ST_FINISH;
          end else if (!seeded_r) begin
            // First draw after reset seeds with the default seed.
            fill_val_nxt = seed_to_word(DEFAULT_SEED);
            state_nxt    = ST_SEED_INIT;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_INIT: begin
        rem_start = 1'b1;
        state_nxt = ST_SEED_DIV;
      end
      ST_SEED_DIV: begin
        if (rem_rsp.done) begin
          disc_cnt_nxt = DISC_BASE + rem_rsp.remainder[DISC_W-1:0];
          fill_idx_nxt = '0;
          state_nxt    = ST_SEED_FILL;
        end
      end
      ST_SEED_FILL: begin
        // One ring word per cycle: u, u+2, u+4, ...
        ring_we      = 1'b1;
        ring_wa      = fill_idx_r;
        ring_wd      = fill_val_r;
        fill_val_nxt = fill_val_r + WORD_W'(2);
        if (fill_idx_r == LAST_IDX) begin
          cur_nxt    = '0;
          seeded_nxt = 1'b1;
          state_nxt  = ST_DRAW_RD;
        end else begin
          fill_idx_nxt = fill_idx_r + CUR_W'(1);
        end
      end
      ST_DRAW_RD: begin
        state_nxt = ST_DRAW_MUL;
      end
      ST_DRAW_MUL: begin
        prod_nxt  = WORD_W'(rd_a_r * rd_b_r);
        state_nxt = ST_DRAW_WB;
      end
      ST_DRAW_WB: begin
        ring_we = 1'b1;
        cur_nxt = (cur_r == LAST_IDX) ? '0 : cur_r + CUR_W'(1);
        if (disc_cnt_r != '0) begin
          // Still discarding after a seeding.
          disc_cnt_nxt = disc_cnt_r - DISC_W'(1);
          if (disc_cnt_r == DISC_W'(1) && op_r == OP_RESEED) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end else begin
          unique case (op_r)
            OP_DRAW29: begin
              res_val_nxt = {{DROP_BITS{1'b0}}, draw_val};
              state_nxt   = ST_FINISH;
            end
            OP_DRAW32: begin
              if (!first_r) begin
                x_nxt     = draw_val;
                first_nxt = 1'b1;
                state_nxt = ST_DRAW_RD;
              end else begin
                res_val_nxt = {{DROP_BITS{1'b0}}, x_r} ^ {draw_val, {DROP_BITS{1'b0}}};
                state_nxt   = ST_FINISH;
              end
            end
            OP_BOUNDED: begin
              rem_start = 1'b1;
              state_nxt = ST_MOD_WAIT;
            end
            OP_RESEED: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_MOD_WAIT: begin
        if (rem_rsp.done) begin
          res_val_nxt = {{(WORD_W - REM_DSR_W){1'b0}}, rem_rsp.remainder};
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the result here until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ring memory: reads run every cycle, the sequencer uses them after ST_DRAW_RD.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    rd_a_r <= ring_mem[cur_r];
    rd_b_r <= ring_mem[part_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seeded_r     <= 1'b0;
      cur_r        <= '0;
      disc_cnt_r   <= '0;
      first_r      <= 1'b0;
      seed_value_r <= DEFAULT_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seeded_r   <= seeded_nxt;
      cur_r      <= cur_nxt;
      disc_cnt_r <= disc_cnt_nxt;
      first_r    <= first_nxt;
      if (cfg_we) begin
        seed_value_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    limit_r    <= limit_nxt;
    x_r        <= x_nxt;
    fill_idx_r <= fill_idx_nxt;
    fill_val_r <= fill_val_nxt;
    prod_r     <= prod_nxt;
    res_val_r  <= res_val_nxt;
    res_bad_r  <= res_bad_nxt;
    out_val_r  <= out_val_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_val_r;
  assign out_bad_limit    = out_bad_r;

  // The remainder unit is never restarted while it is still iterating.
  `LMR_ASSERT_IMPL(a_rem_start_idle, rem_start, !rem_rsp.busy, "remainder unit restarted while busy")
  // A write-back always follows the multiply step.
  `LMR_ASSERT_IMPL(a_wb_after_mul, state_r == ST_DRAW_WB, $past(state_r) == ST_DRAW_MUL, "write-back without multiply")
  // Leaving the fill always starts the discard run.
  `LMR_ASSERT_NEXT(a_fill_discards, state_r == ST_SEED_FILL && state_nxt == ST_DRAW_RD, disc_cnt_r >= DISC_BASE, "seeding left without discard count")
  // An error transaction carries a zero value.
  `LMR_ASSERT_IMPL(a_bad_zero, out_valid && out_bad_limit, out_random_value == '0, "bad limit with nonzero value")

endmodule

`default_nettype wire

/* tb/lagged_multiplicative_rng_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lagged_multiplicative_rng, the lag-55/24 multiplicative generator.
// Depends on lmr_pkg and the RTL only; it keeps its own copy of the ring to predict each result.

module lagged_multiplicative_rng_tb;
  import lmr_pkg::*;

  // Ring geometry, mirrored from the package defaults that the instance uses.
  localparam int RING_LEN    = DEF_LONG_LAG;
  localparam int PARTNER_OFS = RING_LEN - (DEF_SHORT_LAG % RING_LEN);

  // Seeding constants of the generator.
  localparam logic [SEED_W-1:0] BOOT_SEED = SEED_W'(5297);
  localparam int unsigned SKIP_BASE = 400;
  localparam int unsigned SKIP_SPAN = 100;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
  localparam logic [SEED_W-1:0]  SEED_MAX  = {SEED_W{1'b1}};

  localparam int IDLE_PCT     = 18;
  localparam int PHASE_ITEMS  = 112;
  localparam int RANDOM_PHASES = 4;
  // A bounded draw is the slowest non-seeding transaction.
  localparam int TAIL_CYCLES  = 64;
  // A correct run ends far short of this bound.
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    lmr_op_t            op;
    logic [LIMIT_W-1:0] limit;
  } rng_request_t;

  typedef struct {
    lmr_op_t           op;
    logic [WORD_W-1:0] value;
    logic              bad;
  } rng_result_t;

  // Clock, reset and every input of the block start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SEED_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic [1:0] in_operation = OP_DRAW29;
  logic [LIMIT_W-1:0] in_limit = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic [WORD_W-1:0] out_random_value;
  logic out_bad_limit;

  lagged_multiplicative_rng dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_limit         (in_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .out_bad_limit    (out_bad_limit)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  // Requests still to be offered, and the results that accepted requests owe.
  rng_request_t pending_reqs[$];
  rng_result_t  expected_results[$];

  // The predictor's copy of the generator state and of the seed register.
  logic [WORD_W-1:0] rng_words [RING_LEN];
  int unsigned       rng_pos = 0;
  logic              rng_primed = 1'b0;
  logic [SEED_W-1:0] seed_reg = BOOT_SEED;

  // Set by the scoreboard when the request on the bus has been taken.
  logic req_taken = 1'b0;
  // While set, neither side inserts idle cycles.
  logic steady = 1'b0;

  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // One raw step of the lagged recurrence: multiply the word at the cursor by its
  // partner 31 places on, store the product back and return its top 29 bits.
  function automatic logic [DRAW_W-1:0] step_ring();
    int unsigned a;
    int unsigned b;
    logic [WORD_W-1:0] prod;
    a = rng_pos;
    b = (a + PARTNER_OFS) % RING_LEN;
    prod = rng_words[a] * rng_words[b];
    rng_words[a] = prod;
    rng_pos = (a + 1) % RING_LEN;
    return DRAW_W'(prod >> DROP_BITS);
  endfunction

  // Fill the ring with the odd words u, u+2, ... and run the warm-up discards.
  function automatic void reseed_ring(input logic [SEED_W-1:0] s);
    logic [WORD_W-1:0] u;
    int unsigned skips;
    u = (WORD_W'(s) << 1) | WORD_W'(1);
    for (int i = 0; i < RING_LEN; i++) begin
      rng_words[i] = u + WORD_W'(2 * i);
    end
    rng_pos = 0;
    rng_primed = 1'b1;
    skips = SKIP_BASE + (u % SKIP_SPAN);
    for (int unsigned i = 0; i < skips; i++) begin
      void'(step_ring());
    end
  endfunction

  // A draw on an unseeded generator seeds it with the boot seed, not the register.
  function automatic logic [DRAW_W-1:0] next_draw();
    if (!rng_primed) begin
      reseed_ring(BOOT_SEED);
    end
    return step_ring();
  endfunction

  function automatic rng_result_t predict_result(input lmr_op_t op,
                                                 input logic [LIMIT_W-1:0] lim);
    rng_result_t r;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    r.op = op;
    r.value = '0;
    r.bad = 1'b0;
    case (op)
      OP_RESEED: begin
        reseed_ring(seed_reg);
      end
      OP_DRAW29: begin
        r.value = WORD_W'(next_draw());
      end
      OP_DRAW32: begin
        x = WORD_W'(next_draw());
        y = WORD_W'(next_draw());
        r.value = x ^ (y << DROP_BITS);
      end
      OP_BOUNDED: begin
        // A zero limit leaves the state alone, and does not even seed it.
        if (lim == '0) begin
          r.bad = 1'b1;
        end else begin
          r.value = WORD_W'(next_draw()) % WORD_W'(lim);
        end
      end
    endcase
    return r;
  endfunction

  function automatic void queue_request(input lmr_op_t op, input logic [LIMIT_W-1:0] lim);
    rng_request_t req;
    req.op = op;
    req.limit = lim;
    pending_reqs.push_back(req);
  endfunction

  // Random request. Most are draws; bounded draws get a spread of limits that
  // covers zero, tiny values, powers of two, the top of the range and full noise.
  function automatic void queue_random_request();
    int unsigned pick;
    int unsigned shape;
    logic [LIMIT_W-1:0] lim;
    pick = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    lim = LIMIT_W'($urandom);
    if (pick < 5) begin
      queue_request(OP_RESEED, lim);
    end else if (pick < 35) begin
      queue_request(OP_DRAW29, lim);
    end else if (pick < 60) begin
      queue_request(OP_DRAW32, lim);
    end else begin
      case (shape)
        0: lim = '0;
        1: lim = LIMIT_W'($urandom_range(1, 16));
        2: lim = LIMIT_W'(1) << $urandom_range(0, LIMIT_W - 1);
        3: lim = LIMIT_MAX - LIMIT_W'($urandom_range(0, 3));
        default: ;
      endcase
      queue_request(OP_BOUNDED, lim);
    end
  endfunction

  // Returns at a falling edge once nothing is queued, offered or owed.
  task automatic wait_quiet();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // The seed register is only written while the block has nothing in flight.
  task automatic write_seed(input logic [SEED_W-1:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    seed_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The register is moved off its reset value first, so the
    // draw on the fresh block shows that it seeds with the boot seed instead.
    write_seed(SEED_W'(30'h0123_4567));
    // Zero limit on an unseeded block: error flag, and no seeding behind it.
    queue_request(OP_BOUNDED, '0);
    queue_request(OP_DRAW29, '0);
    queue_request(OP_DRAW32, LIMIT_MAX);
    queue_request(OP_BOUNDED, LIMIT_W'(1));
    queue_request(OP_BOUNDED, LIMIT_MAX);
    queue_request(OP_BOUNDED, LIMIT_W'(2));
    queue_request(OP_BOUNDED, LIMIT_W'(31'h4000_0000));
    queue_request(OP_BOUNDED, '0);
    queue_request(OP_RESEED, LIMIT_W'(31'h2AAA_AAAA));
    queue_request(OP_DRAW29, LIMIT_W'(31'h5555_5555));
    queue_request(OP_DRAW32, '0);
    queue_request(OP_BOUNDED, LIMIT_W'(7));

    // The two ends of the seed range.
    write_seed('0);
    queue_request(OP_RESEED, LIMIT_MAX);
    queue_request(OP_DRAW29, '0);
    queue_request(OP_DRAW32, LIMIT_W'(31'h1234_5678));
    queue_request(OP_BOUNDED, LIMIT_W'(3));

    write_seed(SEED_MAX);
    queue_request(OP_RESEED, '0);
    queue_request(OP_DRAW32, LIMIT_MAX);
    queue_request(OP_DRAW29, LIMIT_MAX);
    queue_request(OP_BOUNDED, LIMIT_W'(31'h5555_5555));
    queue_request(OP_BOUNDED, LIMIT_W'(1));

    // Random part: each phase writes a fresh random seed first. One phase runs
    // with both sides flat out, so back-to-back transactions get covered too.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_seed(SEED_W'($urandom));
      steady = (ph == 2);
      repeat (PHASE_ITEMS) queue_random_request();
    end

    // Drain, then give a stray result time to show up before the verdict.
    wait_quiet();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("lagged_multiplicative_rng_tb: done, clean");
    end else begin
      $display("lagged_multiplicative_rng_tb: done, errors");
    end
    $finish;
  end

  // Request driver. A new transaction, or an idle cycle, is only chosen once the
  // one on the bus has been taken, so a stalled payload never moves.
  always @(negedge clk) begin : request_driver
    rng_request_t nxt;
    if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (rst_n && pending_reqs.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_operation <= nxt.op;
        in_limit <= nxt.limit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls at random, except during the steady stretch.
  always @(negedge clk) begin : result_stall
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Scoreboard. Results are checked before new requests are predicted, so a
  // result can never be matched against a request taken at the same edge.
  always @(posedge clk) begin : scoreboard
    rng_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result: value %h bad_limit %b",
                     out_random_value, out_bad_limit);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_random_value !== want.value || out_bad_limit !== want.bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch on %s: value %h bad_limit %b, expected value %h bad_limit %b",
                       want.op.name(), out_random_value, out_bad_limit,
                       want.value, want.bad);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(lmr_op_t'(in_operation), in_limit));
        req_taken = 1'b1;
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lagged_multiplicative_rng_tb: done, errors");
      $finish;
    end
  end

endmodule
